// ===== hdl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int DIST_BITS = 31;
    localparam int VERT_W    = 10;
    localparam int PRED_W    = 11;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int S_DATA_BITS = VERT_W + DIST_BITS + PRED_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = VERT_W + DIST_BITS + PRED_W + CNT_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_EXTRACT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_DONE   = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_ABSENT = 2'd2,
        STS_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [VERT_W-1:0]    vertex;
        logic [DIST_BITS-1:0] distance;
        logic [PRED_W-1:0]    pred;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_LAST,
        S_EX_GET,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Binary min-heap priority queue keyed on distance (shortest-path search).
// Input: s_tvalid/s_tready, s_tuser = command, s_tdata = vertex, distance,
// predecessor. Output: one transfer per command on m_*, m_tuser = status,
// m_tdata = extracted entry (zero unless an extract succeeds) and the live
// entry count after the command. s_tready is high only when the sequencer
// is idle. Heap entries live in a memory with a registered read; at most one
// read or one write is made per cycle. Commands run as follows:
//   clear, load, or update/extract on an empty heap: no search or sift.
//   update: linear scan from the root; on a match the entry is sifted up,
//     moving each parent down while the entry's distance is less.
//   extract: the last entry becomes the new root and is sifted down (up to 9
//     levels), moving the smaller child up while it is less than the entry.
// s_tready rises with m_tvalid.
// If the receiver stalls, the next command is still taken and run, but its
// result waits until the one in the output register has been transferred.
// Reset (aresetn low, synchronous) empties the heap and drops any pending
// result; memory contents are not cleared, only live entries are ever read.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [9:0] vertex, [40:10] distance, [51:41] predecessor
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [9:0] out_vertex, [40:10] out_distance, [51:41] out_predecessor,
    // [62:52] entry_count
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [1:0]                m_tuser
);

    // heap storage, 1-based heap index i lives at address i-1
    entry_t              heap_mem [CAPACITY];
    entry_t              rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    entry_t              mem_wd;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    cmd_t                cmd_reg, cmd_next;
    entry_t              cur_reg, cur_next;      // entry being placed
    entry_t              child_reg, child_next;  // left child during sift-down
    entry_t              root_reg, root_next;    // extracted entry
    logic [CNT_W-1:0]    pos_reg, pos_next;      // current 1-based index
    logic [CNT_W-1:0]    scan_reg, scan_next;    // next address to scan
    logic [CNT_W-1:0]    iss_idx_reg, iss_idx_next;
    logic                iss_valid_reg, iss_valid_next;
    status_t             res_status_reg, res_status_next;
    logic                res_entry_reg, res_entry_next;

    logic                m_tvalid_reg, m_tvalid_next;
    status_t             m_status_reg, m_status_next;
    entry_t              m_entry_reg, m_entry_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;

    entry_t              s_entry;
    cmd_t                s_cmd;
    logic                s_take;
    logic                out_free;
    logic                scan_hit;
    logic                scan_more;
    logic                up_less;
    logic [CNT_W:0]      child_l;
    logic [CNT_W:0]      child_r;
    logic                l_ok;
    logic                r_ok;
    logic                left_less;
    logic [DIST_BITS-1:0] best_d;
    logic                right_less;
    logic [CNT_W-1:0]    parent_idx;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [CNT_W:0] idx);
        logic [CNT_W:0] t;
        t = idx - 1'b1;
        return t[ADDR_W-1:0];
    endfunction

    assign s_entry.vertex   = s_tdata[VERT_W-1:0];
    assign s_entry.distance = s_tdata[VERT_W+DIST_BITS-1:VERT_W];
    assign s_entry.pred     = s_tdata[S_DATA_BITS-1:VERT_W+DIST_BITS];
    assign s_cmd            = cmd_t'(s_tuser);

    assign s_tready = (state_reg == S_IDLE);
    assign s_take   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign scan_hit   = iss_valid_reg && (rd_data_reg.vertex == cur_reg.vertex);
    assign scan_more  = scan_reg < count_reg;
    assign parent_idx = pos_reg >> 1;
    assign up_less    = cur_reg.distance < rd_data_reg.distance;
    assign child_l    = {pos_reg, 1'b0};
    assign child_r    = {pos_reg, 1'b1};
    assign l_ok       = child_l <= {1'b0, count_reg};
    assign r_ok       = child_r <= {1'b0, count_reg};
    assign left_less  = child_reg.distance < cur_reg.distance;
    assign best_d     = left_less ? child_reg.distance : cur_reg.distance;
    assign right_less = r_ok && (rd_data_reg.distance < best_d);

    // heap memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= heap_mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    if (s_cmd == CMD_UPDATE && count_reg != '0) begin
                        state_next = S_SCAN;
                    end else if (s_cmd == CMD_EXTRACT && count_reg != '0) begin
                        state_next = S_EX_LAST;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    state_next = S_UP_CHK;
                end else if (!scan_more) begin
                    state_next = S_RESP;
                end
            end
            S_UP_CHK: begin
                state_next = (pos_reg == CNT_W'(1)) ? S_RESP : S_UP_CMP;
            end
            S_UP_CMP: begin
                state_next = up_less ? S_UP_CHK : S_RESP;
            end
            S_EX_LAST: state_next = S_EX_GET;
            S_EX_GET:  state_next = S_DN_L;
            S_DN_L: begin
                state_next = l_ok ? S_DN_R : S_RESP;
            end
            S_DN_R:    state_next = S_DN_CMP;
            S_DN_CMP: begin
                state_next = (right_less || left_less) ? S_DN_L : S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        cur_next        = cur_reg;
        child_next      = child_reg;
        root_next       = root_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        iss_idx_next    = iss_idx_reg;
        iss_valid_next  = iss_valid_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_entry_next    = m_entry_reg;
        m_count_next    = m_count_reg;
        rd_addr         = '0;
        mem_we          = 1'b0;
        mem_wa          = to_addr({1'b0, pos_reg});
        mem_wd          = cur_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    cmd_next        = s_cmd;
                    cur_next        = s_entry;
                    res_status_next = STS_DONE;
                    res_entry_next  = 1'b0;
                    scan_next       = '0;
                    iss_valid_next  = 1'b0;
                    case (s_cmd)
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_LOAD: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_next = STS_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                mem_wa          = count_reg[ADDR_W-1:0];
                                mem_wd.vertex   = s_entry.vertex;
                                mem_wd.distance = '1;
                                mem_wd.pred     = '1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            if (count_reg == '0) begin
                                res_status_next = STS_ABSENT;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (count_reg == '0) begin
                                res_status_next = STS_EMPTY;
                            end else begin
                                res_entry_next = 1'b1;
                                rd_addr        = '0;   // root
                            end
                        end
                        default: begin
                            res_status_next = STS_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one read issued per cycle, previous read checked
                if (scan_hit) begin
                    pos_next       = iss_idx_reg;
                    iss_valid_next = 1'b0;
                end else if (scan_more) begin
                    rd_addr        = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                    iss_idx_next   = scan_reg + 1'b1;
                    iss_valid_next = 1'b1;
                end else begin
                    iss_valid_next  = 1'b0;
                    res_status_next = STS_ABSENT;
                end
            end
            S_UP_CHK: begin
                if (pos_reg == CNT_W'(1)) begin
                    mem_we = 1'b1;
                end else begin
                    rd_addr = to_addr({1'b0, parent_idx});
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (up_less) begin
                    mem_wd   = rd_data_reg;   // parent moves down into the hole
                    pos_next = parent_idx;
                end
            end
            S_EX_LAST: begin
                root_next = rd_data_reg;
                rd_addr   = to_addr({1'b0, count_reg});
            end
            S_EX_GET: begin
                cur_next   = rd_data_reg;     // last entry becomes the new root
                count_next = count_reg - 1'b1;
                pos_next   = CNT_W'(1);
            end
            S_DN_L: begin
                if (l_ok) begin
                    rd_addr = to_addr(child_l);
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_DN_R: begin
                child_next = rd_data_reg;
                if (r_ok) begin
                    rd_addr = to_addr(child_r);
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (right_less) begin
                    mem_wd   = rd_data_reg;
                    pos_next = child_r[CNT_W-1:0];
                end else if (left_less) begin
                    mem_wd   = child_reg;
                    pos_next = child_l[CNT_W-1:0];
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_entry_next  = res_entry_reg ? root_reg : '0;
                    m_count_next  = count_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_valid_reg <= iss_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        cur_reg        <= cur_next;
        child_reg      <= child_next;
        root_reg       <= root_next;
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        iss_idx_reg    <= iss_idx_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_entry_reg    <= m_entry_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_entry_reg.pred,
                                  m_entry_reg.distance, m_entry_reg.vertex});

endmodule

`default_nettype wire
